FILE: src/dvs_pkg.sv
`timescale 1ns / 1ps
package dvs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int IN_W      = 32;
   localparam int DIFF_W    = IN_W + 1;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int SUM_W     = SQ_W;
   localparam int ROOT_W    = DIFF_W + 1;
   localparam int SQRT_W    = SUM_W + 4;
   localparam int Q_W       = FRAC_BITS + 1;
   localparam int NUM_W     = DIFF_W + FRAC_BITS;
   localparam int DIV_W     = NUM_W + 2;
   localparam int MAG_W     = DIFF_W + 1;
   localparam int LANES     = 3;

   typedef struct packed {
      logic [LANES-1:0][DIFF_W-1:0] d;
      logic [IN_W-1:0]              spd;
      logic                         td;
   } side_type;

   typedef struct packed {
      side_type                  side;
      logic                      len_zero;
      logic [LANES-1:0][Q_W-1:0] q;
   } quot_type;

   // magnitude of a two's complement difference, as unsigned
   function automatic logic [DIFF_W-1:0] mag_of(input logic [DIFF_W-1:0] v);
      logic [DIFF_W-1:0] n;
      n = DIFF_W'(~v + DIFF_W'(1));
      return v[DIFF_W-1] ? n : v;
   endfunction

endpackage

FILE: src/dvs_sqrt.sv
`timescale 1ns / 1ps
module dvs_sqrt import dvs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [SUM_W-1:0]  in_sum,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   logic              valid_ff [ROOT_W];
   logic [SQRT_W-1:0] rem_ff   [ROOT_W-1];
   logic [ROOT_W-1:0] root_ff  [ROOT_W];
   side_type          side_ff  [ROOT_W];

   // one root bit per stage, most significant first
   for (genvar s = 0; s < ROOT_W; s++) begin : gen_stage
      localparam int BIT = ROOT_W - 1 - s;
      logic              v_src;
      logic [SQRT_W-1:0] rem_src;
      logic [ROOT_W-1:0] root_src;
      side_type          side_src;
      logic [SQRT_W-1:0] trial;

      if (s == 0) begin : gen_first
         assign v_src    = in_valid;
         assign rem_src  = SQRT_W'(in_sum);
         assign root_src = '0;
         assign side_src = in_side;
      end else begin : gen_next
         assign v_src    = valid_ff[s-1];
         assign rem_src  = rem_ff[s-1];
         assign root_src = root_ff[s-1];
         assign side_src = side_ff[s-1];
      end

      // (r + 2^i)^2 - r^2
      assign trial = (SQRT_W'(root_src) << (BIT + 1)) + (SQRT_W'(1) << (2 * BIT));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= side_src;
            if (rem_src >= trial) begin
               root_ff[s] <= root_src | (ROOT_W'(1) << BIT);
            end else begin
               root_ff[s] <= root_src;
            end
         end
      end

      if (s < ROOT_W - 1) begin : gen_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= (rem_src >= trial) ? rem_src - trial : rem_src;
            end
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

FILE: src/dvs_div.sv
`timescale 1ns / 1ps
module dvs_div import dvs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [ROOT_W-1:0] in_root,
   input  side_type          in_side,
   output logic              out_valid,
   output quot_type          out_q
);

   logic                         valid_ff [Q_W];
   logic [LANES-1:0][DIV_W-1:0]  rem_ff   [Q_W-1];
   logic [LANES-1:0][Q_W-1:0]    q_ff     [Q_W];
   logic [ROOT_W-1:0]            root_ff  [Q_W];
   side_type                     side_ff  [Q_W];

   // quotient fits in Q_W bits since each |d| that is used is at most the length
   for (genvar s = 0; s < Q_W; s++) begin : gen_stage
      localparam int K = Q_W - 1 - s;
      logic                        v_src;
      logic [LANES-1:0][DIV_W-1:0] rem_src;
      logic [LANES-1:0][DIV_W-1:0] rem_nxt;
      logic [LANES-1:0][Q_W-1:0]   q_src;
      logic [LANES-1:0][Q_W-1:0]   q_nxt;
      logic [ROOT_W-1:0]           root_src;
      side_type                    side_src;
      logic [DIV_W-1:0]            dvs;

      if (s == 0) begin : gen_first
         assign v_src    = in_valid;
         assign root_src = in_root;
         assign side_src = in_side;
         assign q_src    = '0;
         for (genvar l = 0; l < LANES; l++) begin : gen_num
            assign rem_src[l] = DIV_W'(mag_of(in_side.d[l])) << FRAC_BITS;
         end
      end else begin : gen_next
         assign v_src    = valid_ff[s-1];
         assign root_src = root_ff[s-1];
         assign side_src = side_ff[s-1];
         assign q_src    = q_ff[s-1];
         assign rem_src  = rem_ff[s-1];
      end

      assign dvs = DIV_W'(root_src) << K;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            q_nxt[l]   = q_src[l];
            rem_nxt[l] = rem_src[l];
            if (rem_src[l] >= dvs) begin
               rem_nxt[l]  = rem_src[l] - dvs;
               q_nxt[l][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s]    <= q_nxt;
            root_ff[s] <= root_src;
            side_ff[s] <= side_src;
         end
      end

      if (s < Q_W - 1) begin : gen_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= rem_nxt;
            end
         end
      end
   end

   assign out_valid      = valid_ff[Q_W-1];
   assign out_q.side     = side_ff[Q_W-1];
   assign out_q.len_zero = (root_ff[Q_W-1] == '0);
   assign out_q.q        = q_ff[Q_W-1];

endmodule

FILE: src/direction_vector_scale.sv
`timescale 1ns / 1ps
// Scaled direction from a position toward a target, signed Q16.16 throughout.
// One item per cycle is taken while the result side does not stall; results come out
// in order through the difference, square and sum stages, the bit-per-stage square root (34
// stages over the 66-bit sum of squares), the bit-per-stage divider (17
// stages, three lanes in parallel), the multiply stage and the output register. A stall on the result side freezes the
// whole pipeline, so req_ready drops only while a finished result waits.
// In 2D mode z is the raw difference, unscaled; saturated flags any clip.
module direction_vector_scale import dvs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_target_x,
   input  logic [31:0] req_target_y,
   input  logic [31:0] req_target_z,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [31:0] req_speed,
   input  logic        req_three_d,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_step_x,
   output logic [31:0] rsp_step_y,
   output logic [31:0] rsp_step_z,
   output logic        rsp_saturated
);

   logic pipe_en;

   // stage 1: differences and magnitudes
   logic                         s1_valid_ff;
   side_type                     s1_side_ff;
   logic [LANES-1:0][DIFF_W-1:0] s1_mag_ff;
   side_type                     s1_side_in;

   // stage 2: squares, z dropped in 2D
   logic                         s2_valid_ff;
   side_type                     s2_side_ff;
   logic [LANES-1:0][SQ_W-1:0]   s2_sq_ff;

   // stage 3: sum of squares
   logic                         s3_valid_ff;
   side_type                     s3_side_ff;
   logic [SUM_W-1:0]             s3_sum_ff;

   logic                         rt_valid;
   logic [ROOT_W-1:0]            rt_root;
   side_type                     rt_side;

   logic                         dv_valid;
   quot_type                     dv_q;

   // multiply stage
   logic                         mul_valid_ff;
   logic [LANES-1:0][MAG_W-1:0]  mul_base_ff;
   logic [LANES-1:0][Q_W+30:0]   mul_prod_ff;
   logic [LANES-1:0]             mul_sc_ff;
   logic [LANES-1:0]             mul_neg_ff;
   logic [LANES-1:0][MAG_W-1:0]  mul_base_in;
   logic [LANES-1:0][Q_W+30:0]   mul_prod_in;
   logic [LANES-1:0]             mul_sc_in;
   logic [LANES-1:0]             mul_neg_in;

   // output register
   logic                         rsp_valid_ff;
   logic [LANES-1:0][31:0]       rsp_step_ff;
   logic                         rsp_sat_ff;
   logic [LANES-1:0][31:0]       rsp_step_in;
   logic                         rsp_sat_in;

   assign pipe_en   = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_en;

   always_comb begin
      s1_side_in.d[0] = DIFF_W'({req_target_x[31], req_target_x} - {req_pos_x[31], req_pos_x});
      s1_side_in.d[1] = DIFF_W'({req_target_y[31], req_target_y} - {req_pos_y[31], req_pos_y});
      s1_side_in.d[2] = DIFF_W'({req_target_z[31], req_target_z} - {req_pos_z[31], req_pos_z});
      s1_side_in.spd  = req_speed;
      s1_side_in.td   = req_three_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         mul_valid_ff <= dv_valid;
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_side_ff <= s1_side_in;
         for (int l = 0; l < LANES; l++) begin
            s1_mag_ff[l] <= mag_of(s1_side_in.d[l]);
         end
         s2_side_ff  <= s1_side_ff;
         s2_sq_ff[0] <= s1_mag_ff[0] * s1_mag_ff[0];
         s2_sq_ff[1] <= s1_mag_ff[1] * s1_mag_ff[1];
         s2_sq_ff[2] <= s1_side_ff.td ? s1_mag_ff[2] * s1_mag_ff[2] : '0;
         s3_side_ff  <= s2_side_ff;
         s3_sum_ff   <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
      end
   end

   dvs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s3_valid_ff),
      .in_sum    (s3_sum_ff),
      .in_side   (s3_side_ff),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   dvs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (rt_valid),
      .in_root   (rt_root),
      .in_side   (rt_side),
      .out_valid (dv_valid),
      .out_q     (dv_q)
   );

   // pick normalized or raw magnitude, then scale by a positive speed
   always_comb begin
      logic spd_pos;
      logic used;
      spd_pos = !dv_q.side.spd[31] && (dv_q.side.spd != '0);
      for (int l = 0; l < LANES; l++) begin
         used = (l < 2) || dv_q.side.td;
         if (used && !dv_q.len_zero) begin
            mul_base_in[l] = MAG_W'(dv_q.q[l]);
         end else begin
            mul_base_in[l] = MAG_W'(mag_of(dv_q.side.d[l]));
         end
         mul_sc_in[l]   = used && spd_pos;
         mul_neg_in[l]  = dv_q.side.d[l][DIFF_W-1];
         mul_prod_in[l] = mul_base_in[l][Q_W-1:0] * dv_q.side.spd[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mul_base_ff <= mul_base_in;
         mul_prod_ff <= mul_prod_in;
         mul_sc_ff   <= mul_sc_in;
         mul_neg_ff  <= mul_neg_in;
      end
   end

   // shift back, restore sign, clip to 32 bits
   always_comb begin
      logic [MAG_W-1:0] mag;
      rsp_sat_in = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         mag = mul_sc_ff[l] ? MAG_W'(mul_prod_ff[l] >> FRAC_BITS) : mul_base_ff[l];
         if (!mul_neg_ff[l] && (mag > MAG_W'(32'h7fff_ffff))) begin
            rsp_step_in[l] = 32'h7fff_ffff;
            rsp_sat_in     = 1'b1;
         end else if (mul_neg_ff[l] && (mag > MAG_W'(32'h8000_0000))) begin
            rsp_step_in[l] = 32'h8000_0000;
            rsp_sat_in     = 1'b1;
         end else begin
            rsp_step_in[l] = mul_neg_ff[l] ? 32'(~mag + MAG_W'(1)) : mag[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_step_ff <= rsp_step_in;
         rsp_sat_ff  <= rsp_sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_step_x    = rsp_step_ff[0];
   assign rsp_step_y    = rsp_step_ff[1];
   assign rsp_step_z    = rsp_step_ff[2];
   assign rsp_saturated = rsp_sat_ff;

`ifndef SYNTH
   // a clipped result must show a rail value somewhere
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_step_x == 32'h7fff_ffff || rsp_step_x == 32'h8000_0000 ||
         rsp_step_y == 32'h7fff_ffff || rsp_step_y == 32'h8000_0000 ||
         rsp_step_z == 32'h7fff_ffff || rsp_step_z == 32'h8000_0000)
      else $error("saturated flag without clipped component");

   // a stall freezes the front of the pipe
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(s1_valid_ff) && $stable(s1_side_ff))
      else $error("pipeline advanced during stall");

   // normalized x and y magnitudes never exceed one when a positive speed scales them
   a_norm_bound: assert property (@(posedge clock) disable iff (reset)
      mul_valid_ff && mul_sc_ff[0] |-> mul_base_ff[0] <= (MAG_W'(1) << FRAC_BITS))
      else $error("normalized x above unity");

   a_norm_bound_y: assert property (@(posedge clock) disable iff (reset)
      mul_valid_ff && mul_sc_ff[1] |-> mul_base_ff[1] <= (MAG_W'(1) << FRAC_BITS))
      else $error("normalized y above unity");
`endif

endmodule

FILE: bench/direction_vector_scale_tb.sv
`timescale 1ns / 1ps
module direction_vector_scale_tb;
   import dvs_pkg::*;

   localparam int N_RANDOM    = 1900;
   localparam int PIPE_CYCLES = 56;
   localparam int LONG_HOLD   = 300;

   typedef struct packed {
      logic [2:0][31:0] tgt;
      logic [2:0][31:0] pos;
      logic [31:0]      speed;
      logic             td;
   } vec_in_type;

   typedef struct packed {
      logic [31:0] sx;
      logic [31:0] sy;
      logic [31:0] sz;
      logic        sat;
   } step_type;

   typedef struct {
      vec_in_type stim;
      bit         typed;
      step_type   want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [31:0] req_speed = '0;
   logic        req_three_d = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_step_x, rsp_step_y, rsp_step_z;
   logic        rsp_saturated;

   step_type pending_steps[$];
   row_type  table_rows[$];
   bit       failed = 0;
   bit       sending_done = 0;
   int       steps_seen = 0;

   always #10 clock = ~clock;

   direction_vector_scale dut (.*);

   // clip to 32-bit signed, flag any clip
   function automatic logic [31:0] clip32(input longint v, inout bit sat);
      if (v > 64'sh7FFF_FFFF) begin
         sat = 1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
         sat = 1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // difference, integer square-root length, normalize by length, scale by positive speed
   function automatic step_type predict_step(input vec_in_type a);
      longint            d[3];
      longint unsigned   m[3];
      logic [65:0]       sumsq;
      logic [33:0]       len, cand;
      logic [67:0]       sq;
      longint            spd;
      longint unsigned   mag;
      bit                sat;
      int                used;
      step_type          s;
      sat = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = longint'($signed(a.tgt[i])) - longint'($signed(a.pos[i]));
         m[i] = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
      end
      used = a.td ? 3 : 2;
      sumsq = '0;
      for (int i = 0; i < used; i++)
         sumsq += 66'(m[i]) * 66'(m[i]);
      len = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = len | (34'd1 << b);
         sq = 68'(cand) * 68'(cand);
         if (sq <= 68'(sumsq))
            len = cand;
      end
      spd = longint'($signed(a.speed));
      for (int i = 0; i < used; i++) begin
         if (len != 0) begin
            mag = (m[i] << FRAC_BITS) / longint'(len);
            d[i] = d[i] < 0 ? -longint'(mag) : longint'(mag);
         end
         if (spd > 0) begin
            mag = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
            mag = (mag * longint'(spd)) >> FRAC_BITS;
            d[i] = d[i] < 0 ? -longint'(mag) : longint'(mag);
         end
      end
      s.sx = clip32(d[0], sat);
      s.sy = clip32(d[1], sat);
      s.sz = clip32(d[2], sat);
      s.sat = sat;
      return s;
   endfunction

   function automatic vec_in_type make_vec(input logic [31:0] tx, ty, tz, px, py, pz,
                                           input logic [31:0] spd, input logic td);
      vec_in_type v;
      v.tgt = {tz, ty, tx};
      v.pos = {pz, py, px};
      v.speed = spd;
      v.td = td;
      return v;
   endfunction

   task automatic add_row(input vec_in_type v, input bit typed, input step_type w = '0);
      row_type r;
      r.stim = v;
      r.typed = typed;
      r.want = w;
      table_rows.push_back(r);
   endtask

   function automatic logic [31:0] rand_speed();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'h8000_0000 | $urandom();
         2: return $urandom_range(1, 32'h0004_0000);
         default: return $urandom() & 32'h7FFF_FFFF;
      endcase
   endfunction

   // mostly nearby points, where the length is small and rounding is visible
   function automatic vec_in_type rand_vec();
      vec_in_type v;
      int         kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++) begin
         v.pos[i] = $urandom();
         case (kind)
            0, 1, 2: v.tgt[i] = $urandom();
            7:       v.tgt[i] = v.pos[i];
            8:       v.tgt[i] = v.pos[i] + $urandom_range(0, 8) - 4;
            default: v.tgt[i] = v.pos[i] + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         endcase
      end
      v.speed = rand_speed();
      v.td = $urandom_range(0, 1);
      return v;
   endfunction

   task automatic send_vec(input vec_in_type v, input bit typed, input step_type w);
      int  gap;
      bit  rdy;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0)
         gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_target_x <= v.tgt[0];
      req_target_y <= v.tgt[1];
      req_target_z <= v.tgt[2];
      req_pos_x    <= v.pos[0];
      req_pos_y    <= v.pos[1];
      req_pos_z    <= v.pos[2];
      req_speed    <= v.speed;
      req_three_d  <= v.td;
      // sample ready mid-cycle, where it is settled
      do begin
         @(negedge clock);
         rdy = req_ready;
         @(posedge clock);
      end while (!rdy);
      pending_steps.push_back(typed ? w : predict_step(v));
   endtask

   task automatic check_step(input step_type got);
      step_type w;
      if (pending_steps.size() == 0) begin
         $error("unexpected transfer on rsp: x=%h y=%h z=%h", got.sx, got.sy, got.sz);
         failed = 1;
         return;
      end
      w = pending_steps.pop_front();
      if (got.sx !== w.sx) begin
         $error("step_x expected %h actual %h", w.sx, got.sx);
         failed = 1;
      end
      if (got.sy !== w.sy) begin
         $error("step_y expected %h actual %h", w.sy, got.sy);
         failed = 1;
      end
      if (got.sz !== w.sz) begin
         $error("step_z expected %h actual %h", w.sz, got.sz);
         failed = 1;
      end
      if (got.sat !== w.sat) begin
         $error("saturated expected %b actual %b", w.sat, got.sat);
         failed = 1;
      end
   endtask

   // sender: directed table, then random vectors
   initial begin
      vec_in_type v;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero: zero length, no division, with zero and with largest speed
      add_row(make_vec(0, 0, 0, 0, 0, 0, 0, 1'b0), 1, '0);
      add_row(make_vec(0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 1'b1), 1, '0);
      // widest x span, no scaling: unit vector along x
      add_row(make_vec(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 0, 1'b0), 1,
              '{32'h0001_0000, 32'h0, 32'h0, 1'b0});
      // unit vector times largest speed just fits
      add_row(make_vec(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 1'b1), 1,
              '{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0});
      add_row(make_vec(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1'b0), 1,
              '{32'h8000_0001, 32'h0, 32'h0, 1'b0});
      // 2D: raw z difference clips both ways
      add_row(make_vec(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 32'h0001_0000, 1'b0), 1,
              '{32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1});
      add_row(make_vec(0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0), 1,
              '{32'h0, 32'h0, 32'h8000_0000, 1'b1});
      // 2D z in range passes through unscaled
      add_row(make_vec(0, 0, 32'h0000_1234, 0, 0, 0, 32'h0003_0000, 1'b0), 1,
              '{32'h0, 32'h0, 32'h0000_1234, 1'b0});
      // same span in 3D gets normalized
      add_row(make_vec(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 1'b1), 1,
              '{32'h0, 32'h0, 32'h0001_0000, 1'b0});
      // negative speed and the most negative speed: no scaling
      add_row(make_vec(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'hFFFF_FFFF, 1'b0), 0);
      add_row(make_vec(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'h8000_0000, 1'b1), 0);
      add_row(make_vec(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 32'h0002_0000, 1'b0), 0);
      add_row(make_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1), 0);
      add_row(make_vec(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1), 0);
      add_row(make_vec(1, 1, 1, 0, 0, 0, 32'h0001_0000, 1'b1), 0);
      add_row(make_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 1'b0), 0);
      add_row(make_vec(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                       32'hFFFF_FFFF, 1'b1), 0);

      foreach (table_rows[i])
         send_vec(table_rows[i].stim, table_rows[i].typed, table_rows[i].want);
      for (int n = 0; n < N_RANDOM; n++) begin
         v = rand_vec();
         send_vec(v, 0, '0);
      end
      req_valid <= 1'b0;
      sending_done = 1;
   end

   // receiver: random stalls, one long hold-off to back the pipeline up
   initial begin
      int       stall;
      bit       vld;
      step_type got;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 7);
         if ($urandom_range(0, 3) == 0)
            stall = 0;
         if (steps_seen == 400)
            stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            vld = rsp_valid;
            got = '{rsp_step_x, rsp_step_y, rsp_step_z, rsp_saturated};
            @(posedge clock);
         end while (!vld);
         steps_seen++;
         check_step(got);
      end
   end

   // end of run: drain, then let the pipeline latency pass for strays
   initial begin
      wait (sending_done);
      while (pending_steps.size() != 0)
         @(posedge clock);
      repeat (PIPE_CYCLES + 20) @(posedge clock);
      if (!failed && pending_steps.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule
